// File: sv/lsp_pkg.sv
// Shared types, constants and CORDIC tables for the log spiral point generator.
// Used by every module of the block; depends on nothing.
package lsp_pkg;

    // Default parameter values
    localparam int IN_WIDTH_DEF      = 16;
    localparam int OUT_WIDTH_DEF     = 32;
    localparam int CORDIC_STAGES_DEF = 16;

    // Datapath widths: Q29 values, widened remainder, binary exponent
    localparam int D_W = 34;
    localparam int V_W = D_W + 4;
    localparam int K_W = 9;

    // Pipeline depth outside the CORDIC stages
    localparam int FRONT_STAGES = 7;
    localparam int BACK_STAGES  = 4;

    typedef logic signed [D_W-1:0] dat_t;
    typedef logic signed [K_W-1:0] exp_t;

    localparam dat_t PI_Q29    = 34'sd1686629713;
    localparam dat_t LN2_Q29   = 34'sd372130559;
    localparam dat_t INVKC_Q29 = 34'sd326016437;
    localparam dat_t INVKH_Q29 = 34'sd648270052;

    // Reciprocal of ln2 in Q29 scaled by 2^RECIP_SH; estimate is off by at most one
    localparam int RECIP_LN2 = 185;
    localparam int RECIP_SH  = 36;

    // Product E*C carries 58 fraction bits; output has 16
    localparam int SCALE_BIAS = 42;

    // State of both rotators as it travels down the pipeline
    typedef struct packed {
        dat_t hx;
        dat_t hy;
        dat_t hz;
        dat_t cx;
        dat_t cy;
        dat_t cz;
        exp_t k;
        logic flip;
    } cordic_t;

    // Shift index of hyperbolic stage n, with repeats at 4, 13, 40, ...
    function automatic int hyp_shift(input int n);
        int i;
        int rep;
        int j;
        i = 1;
        rep = 4;
        for (j = 0; j < n; j++)
        begin
            if (i == rep)
                rep = 3 * rep + 1;
            else
                i = i + 1;
        end
        return i;
    endfunction

    function automatic dat_t small_angle(input int i);
        if (i > 29)
            return '0;
        return dat_t'(34'sd1 <<< (29 - i));
    endfunction

    function automatic dat_t atan_of(input int i);
        case (i)
            0: return 34'sd421657428;
            1: return 34'sd248918915;
            2: return 34'sd131521918;
            3: return 34'sd66762579;
            4: return 34'sd33510843;
            5: return 34'sd16771758;
            6: return 34'sd8387925;
            7: return 34'sd4194219;
            8: return 34'sd2097141;
            9: return 34'sd1048575;
            default: return small_angle(i);
        endcase
    endfunction

    function automatic dat_t atanh_of(input int i);
        case (i)
            0: return 34'sd0;
            1: return 34'sd294906491;
            2: return 34'sd137123709;
            3: return 34'sd67461703;
            4: return 34'sd33598226;
            5: return 34'sd16782681;
            6: return 34'sd8389291;
            7: return 34'sd4194389;
            8: return 34'sd2097163;
            9: return 34'sd1048577;
            default: return small_angle(i);
        endcase
    endfunction

endpackage

// File: sv/log_spiral_point_generator.sv
// Log spiral point generator: each position item gives one (X, Y) point with
// r = exp(a*pi*x) and angle pi*x, a taken from the growth register. The block
// accepts one item per clock while the output is not held; an item passes
// through the front end (7 stages), one stage per CORDIC rotation and the
// scaling back end (4 stages). When the output item is held, the whole pipeline
// holds and s_tready drops. Write the growth register only while idle.
// Depends on lsp_pkg, lsp_front, lsp_cordic_stage and lsp_scale.
module log_spiral_point_generator #(
    parameter int IN_WIDTH      = lsp_pkg::IN_WIDTH_DEF,
    parameter int OUT_WIDTH     = lsp_pkg::OUT_WIDTH_DEF,
    parameter int CORDIC_STAGES = lsp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // position
    input  logic [((IN_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // coord_x, coord_y
    output logic [((2*OUT_WIDTH+7)/8)*8-1:0]    m_tdata,
    // overflow
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [15:0]                         cfg_data
);
    import lsp_pkg::*;

    localparam int NST  = FRONT_STAGES + CORDIC_STAGES + BACK_STAGES;
    localparam int OTDW = ((2 * OUT_WIDTH + 7) / 8) * 8;

    logic signed [15:0]          growth_reg;
    logic [NST-1:0]              vld_reg;
    logic                        en;
    cordic_t                     chain [0:CORDIC_STAGES];
    logic signed [OUT_WIDTH-1:0] coord_x, coord_y;
    logic                        overflow;

    // Hold the pipeline while the output item waits
    assign en        = ~vld_reg[NST-1] | m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            growth_reg <= '0;
        else if (cfg_valid)
            growth_reg <= $signed(cfg_data);
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    lsp_front #(
        .IN_WIDTH (IN_WIDTH)
    ) u_front (
        .clk      (clk),
        .en       (en),
        .position ($signed(s_tdata[IN_WIDTH-1:0])),
        .growth   (growth_reg),
        .init     (chain[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        lsp_cordic_stage #(
            .HSH  (hyp_shift(g)),
            .CSH  (g),
            .HANG (atanh_of(hyp_shift(g))),
            .CANG (atan_of(g))
        ) u_stage (
            .clk    (clk),
            .en     (en),
            .st_in  (chain[g]),
            .st_out (chain[g+1])
        );
    end

    lsp_scale #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_scale (
        .clk      (clk),
        .en       (en),
        .st_in    (chain[CORDIC_STAGES]),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .overflow (overflow)
    );

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = OTDW'({coord_y, coord_x});
    assign m_tuser  = overflow;

endmodule

// File: sv/lsp_front.sv
// Front end: angle, radius exponent split into k*ln2 + f, and angle fold.
// Seven register stages; depends on lsp_pkg.
module lsp_front #(
    parameter int IN_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [IN_WIDTH-1:0] position,
    input  logic signed [15:0]         growth,
    output lsp_pkg::cordic_t           init
);
    import lsp_pkg::*;

    localparam int FRAC = IN_WIDTH - 2;
    localparam int PW   = IN_WIDTH + D_W;
    localparam int AW   = D_W + 16;
    localparam int QW   = V_W + 10;
    localparam logic signed [PW-1:0] RND_IN  = PW'(1) <<< (FRAC - 1);
    localparam logic signed [IN_WIDTH-1:0] HALF = IN_WIDTH'(1) <<< (IN_WIDTH - 3);
    localparam logic signed [AW-1:0] RND_A   = AW'(1) <<< 11;

    logic signed [IN_WIDTH-1:0] t_raw;
    logic signed [IN_WIDTH-1:0] t_fold;
    logic                       flip_next;
    logic signed [PW-1:0]       pphi_reg, pz_reg;
    logic                       flip1_reg, flip2_reg, flip3_reg, flip4_reg;
    logic                       flip5_reg, flip6_reg, flip7_reg;
    dat_t                       phi_reg, z2_reg, z3_reg, z4_reg, z5_reg, z6_reg, z7_reg;
    logic signed [PW-1:0]       sum_phi, sum_z;
    logic signed [AW-1:0]       pa_reg, sum_a;
    logic signed [V_W-1:0]      v4_reg, v5_reg, rem_reg;
    logic signed [QW-1:0]       qp_next;
    exp_t                       q5_reg, q6_reg, k_reg;
    exp_t                       k_next;
    dat_t                       f_reg, f_next;

    // Fold the phase to [-1/2, 1/2] of pi, noting a half turn
    always_comb
    begin
        t_raw     = IN_WIDTH'($signed(position[IN_WIDTH-2:0]));
        t_fold    = t_raw;
        flip_next = 1'b0;
        if (t_raw > HALF)
        begin
            t_fold    = t_raw - (HALF <<< 1);
            flip_next = 1'b1;
        end
        else if (t_raw < -HALF)
        begin
            t_fold    = t_raw + (HALF <<< 1);
            flip_next = 1'b1;
        end
    end

    assign sum_phi = pphi_reg + RND_IN;
    assign sum_z   = pz_reg + RND_IN;
    assign sum_a   = pa_reg + RND_A;
    assign qp_next = QW'(v4_reg) * QW'(RECIP_LN2);

    // Correct the quotient estimate by one step
    always_comb
    begin
        k_next = q6_reg;
        f_next = D_W'(rem_reg);
        if (rem_reg < 0)
        begin
            k_next = q6_reg - exp_t'(1);
            f_next = D_W'(rem_reg + V_W'(LN2_Q29));
        end
        else if (rem_reg >= V_W'(LN2_Q29))
        begin
            k_next = q6_reg + exp_t'(1);
            f_next = D_W'(rem_reg - V_W'(LN2_Q29));
        end
    end

    // Advance all front stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pphi_reg  <= PW'(position) * PW'(PI_Q29);
            pz_reg    <= PW'(t_fold) * PW'(PI_Q29);
            flip1_reg <= flip_next;

            phi_reg   <= sum_phi[FRAC +: D_W];
            z2_reg    <= sum_z[FRAC +: D_W];
            flip2_reg <= flip1_reg;

            pa_reg    <= AW'(phi_reg) * AW'(growth);
            z3_reg    <= z2_reg;
            flip3_reg <= flip2_reg;

            v4_reg    <= sum_a[12 +: V_W];
            z4_reg    <= z3_reg;
            flip4_reg <= flip3_reg;

            q5_reg    <= qp_next[RECIP_SH +: K_W];
            v5_reg    <= v4_reg;
            z5_reg    <= z4_reg;
            flip5_reg <= flip4_reg;

            rem_reg   <= v5_reg - V_W'(q5_reg) * V_W'(LN2_Q29);
            q6_reg    <= q5_reg;
            z6_reg    <= z5_reg;
            flip6_reg <= flip5_reg;

            k_reg     <= k_next;
            f_reg     <= f_next;
            z7_reg    <= z6_reg;
            flip7_reg <= flip6_reg;
        end
    end

    // Seed both rotators
    always_comb
    begin
        init.hx   = INVKH_Q29;
        init.hy   = '0;
        init.hz   = f_reg;
        init.cx   = INVKC_Q29;
        init.cy   = '0;
        init.cz   = z7_reg;
        init.k    = k_reg;
        init.flip = flip7_reg;
    end

endmodule

// File: sv/lsp_cordic_stage.sv
// One pipeline stage holding one hyperbolic and one circular CORDIC rotation.
// Depends on lsp_pkg.
module lsp_cordic_stage #(
    parameter int           HSH  = 1,
    parameter int           CSH  = 0,
    parameter lsp_pkg::dat_t HANG = '0,
    parameter lsp_pkg::dat_t CANG = '0
) (
    input  logic             clk,
    input  logic             en,
    input  lsp_pkg::cordic_t st_in,
    output lsp_pkg::cordic_t st_out
);
    import lsp_pkg::*;

    dat_t    hx, hy, hz, cx, cy, cz;
    dat_t    hdx, hdy, cdx, cdy;
    cordic_t st_next, st_reg;

    assign hx  = st_in.hx;
    assign hy  = st_in.hy;
    assign hz  = st_in.hz;
    assign cx  = st_in.cx;
    assign cy  = st_in.cy;
    assign cz  = st_in.cz;
    assign hdx = hy >>> HSH;
    assign hdy = hx >>> HSH;
    assign cdx = cy >>> CSH;
    assign cdy = cx >>> CSH;

    // Rotate toward zero residual angle
    always_comb
    begin
        st_next = st_in;
        if (hz >= 0)
        begin
            st_next.hx = hx + hdx;
            st_next.hy = hy + hdy;
            st_next.hz = hz - HANG;
        end
        else
        begin
            st_next.hx = hx - hdx;
            st_next.hy = hy - hdy;
            st_next.hz = hz + HANG;
        end
        if (cz >= 0)
        begin
            st_next.cx = cx - cdx;
            st_next.cy = cy + cdy;
            st_next.cz = cz - CANG;
        end
        else
        begin
            st_next.cx = cx + cdx;
            st_next.cy = cy - cdy;
            st_next.cz = cz + CANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign st_out = st_reg;

endmodule

// File: sv/lsp_scale.sv
// Back end: radius times cos/sin, scaling by 2^k, rounding and saturation.
// Four register stages; depends on lsp_pkg.
module lsp_scale #(
    parameter int OUT_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        en,
    input  lsp_pkg::cordic_t            st_in,
    output logic signed [OUT_WIDTH-1:0] coord_x,
    output logic signed [OUT_WIDTH-1:0] coord_y,
    output logic                        overflow
);
    import lsp_pkg::*;

    localparam int RW = 97;
    localparam int SW = K_W + 2;
    localparam logic signed [RW-1:0] HI = (RW'(1) <<< (OUT_WIDTH - 1)) - RW'(1);
    localparam logic signed [RW-1:0] LO = -HI - RW'(1);

    dat_t                    e_reg, c_reg, s_reg;
    exp_t                    k1_reg, k2_reg;
    logic signed [63:0]      pc_reg, ps_reg;
    logic signed [RW-1:0]    rx_reg, ry_reg;
    logic signed [SW-1:0]    shv;
    logic signed [OUT_WIDTH-1:0] x_next, y_next, x_reg, y_reg;
    logic                    satx, saty, ovf_reg;

    // Round by the right shift, or move left; tiny radii give zero
    function automatic logic signed [RW-1:0] scale_fn(input logic signed [63:0] p,
                                                       input logic signed [SW-1:0] sh);
        logic signed [RW-1:0] pw;
        logic signed [SW-1:0] nsh;
        pw  = RW'(p);
        nsh = -sh;
        if (sh >= SW'(62))
            return '0;
        if (sh > SW'(0))
            return (pw + (RW'(1) <<< (sh[6:0] - 7'd1))) >>> sh[6:0];
        return pw <<< nsh[6:0];
    endfunction

    assign shv = SW'(SCALE_BIAS) - SW'(k2_reg);

    // Clamp to the output range
    always_comb
    begin
        satx   = 1'b0;
        saty   = 1'b0;
        x_next = rx_reg[OUT_WIDTH-1:0];
        y_next = ry_reg[OUT_WIDTH-1:0];
        if (rx_reg > HI)
        begin
            x_next = HI[OUT_WIDTH-1:0];
            satx   = 1'b1;
        end
        else if (rx_reg < LO)
        begin
            x_next = LO[OUT_WIDTH-1:0];
            satx   = 1'b1;
        end
        if (ry_reg > HI)
        begin
            y_next = HI[OUT_WIDTH-1:0];
            saty   = 1'b1;
        end
        else if (ry_reg < LO)
        begin
            y_next = LO[OUT_WIDTH-1:0];
            saty   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg   <= st_in.hx + st_in.hy;
            c_reg   <= st_in.flip ? -st_in.cx : st_in.cx;
            s_reg   <= st_in.flip ? -st_in.cy : st_in.cy;
            k1_reg  <= st_in.k;

            pc_reg  <= 64'($signed(e_reg[31:0])) * 64'($signed(c_reg[31:0]));
            ps_reg  <= 64'($signed(e_reg[31:0])) * 64'($signed(s_reg[31:0]));
            k2_reg  <= k1_reg;

            rx_reg  <= scale_fn(pc_reg, shv);
            ry_reg  <= scale_fn(ps_reg, shv);

            x_reg   <= x_next;
            y_reg   <= y_next;
            ovf_reg <= satx | saty;
        end
    end

    assign coord_x  = x_reg;
    assign coord_y  = y_reg;
    assign overflow = ovf_reg;

endmodule

// File: sv/lsp_checker.sv
// Port-level checks for the log spiral point generator, bound to the top level.
// Depends only on the top level's ports.
module lsp_checker #(
    parameter int OUT_WIDTH = 32,
    parameter int OTDW      = 64
) (
    input logic            clk,
    input logic            rst_n,
    input logic            s_tready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [OTDW-1:0] m_tdata,
    input logic [0:0]      m_tuser
);
    localparam logic [OUT_WIDTH-1:0] MAXV = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] MINV = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    logic [OUT_WIDTH-1:0] xv, yv;
    assign xv = m_tdata[OUT_WIDTH-1:0];
    assign yv = m_tdata[2*OUT_WIDTH-1:OUT_WIDTH];

    // Held item stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // Held item keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // Overflow only with a clamped coordinate
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> xv == MAXV || xv == MINV || yv == MAXV || yv == MINV)
        else $error("overflow without saturated coordinate");

    // Empty output never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind log_spiral_point_generator lsp_checker #(
    .OUT_WIDTH (OUT_WIDTH),
    .OTDW      (((2 * OUT_WIDTH + 7) / 8) * 8)
) u_lsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/log_spiral_point_generator_test.sv
// Testbench for the log spiral point generator: drives position items through
// the stream ports, predicts every point in fixed point, and checks results.
// Depends on lsp_pkg and log_spiral_point_generator.
`timescale 1ns / 1ps

class spiral_scoreboard;
    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic        ovf;
    } point_t;

    point_t          pending[$];
    logic [15:0]     growth;
    int              errors;

    function new();
        growth = '0;
        errors = 0;
    endfunction

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    static function longint circ_angle(int i);
        longint tab[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                            16771758, 8387925, 4194219, 2097141, 1048575};
        if (i < 10) return tab[i];
        return (i > 29) ? 0 : (longint'(1) << (29 - i));
    endfunction

    static function longint hyp_angle(int i);
        longint tab[10] = '{0, 294906491, 137123709, 67461703, 33598226,
                            16782681, 8389291, 4194389, 2097163, 1048577};
        if (i < 10) return tab[i];
        return (i > 29) ? 0 : (longint'(1) << (29 - i));
    endfunction

    // Scale E*C by 2^(k-42) with rounding, then clamp to 32 signed bits
    static function longint scale_clamp(longint prod, longint k, ref bit sat);
        longint hi, lo, s, r;
        int sh;
        hi = (longint'(1) << 31) - 1;
        lo = -hi - 1;
        s = 42 - k;
        if (s >= 62) return 0;
        if (s > 0)
            r = round_shift(prod, int'(s));
        else
        begin
            sh = int'(-s);
            if (prod > (hi >>> sh)) begin sat = 1; return hi; end
            if (prod < -((hi + 1) >>> sh)) begin sat = 1; return lo; end
            r = prod <<< sh;
        end
        if (r > hi) begin sat = 1; return hi; end
        if (r < lo) begin sat = 1; return lo; end
        return r;
    endfunction

    // Note an accepted position item and queue its expected point
    function void note_position(logic [15:0] pos);
        longint x, a, phi, v, k, f, hx, hy, hz, cx, cy, cz, dx, dy, t, e, px, py;
        int i, rep, n;
        bit flip, sat;
        point_t pt;
        flip = 0;
        sat = 0;
        x = longint'($signed(pos));
        a = longint'($signed(growth));
        phi = round_shift(x * 64'sd1686629713, 14);
        v = round_shift(a * phi, 12);
        k = v / 372130559;
        if (v < 0 && k * 372130559 != v) k--;
        f = v - k * 372130559;
        // Hyperbolic rotation for e^f
        hx = 648270052; hy = 0; hz = f; i = 1; rep = 4;
        for (n = 0; n < 16; n++)
        begin
            dx = floor_shift(hy, i);
            dy = floor_shift(hx, i);
            if (hz >= 0) begin hx += dx; hy += dy; hz -= hyp_angle(i); end
            else begin hx -= dx; hy -= dy; hz += hyp_angle(i); end
            if (i == rep) rep = 3 * rep + 1;
            else i++;
        end
        e = hx + hy;
        // Fold the phase into [-1/2, 1/2] turns of pi
        t = longint'(pos[14:0]);
        if (t >= 16384) t -= 32768;
        if (t > 8192) begin t -= 16384; flip = 1; end
        else if (t < -8192) begin t += 16384; flip = 1; end
        cz = round_shift(t * 64'sd1686629713, 14);
        cx = 326016437; cy = 0;
        for (n = 0; n < 16; n++)
        begin
            dx = floor_shift(cy, n);
            dy = floor_shift(cx, n);
            if (cz >= 0) begin cx -= dx; cy += dy; cz -= circ_angle(n); end
            else begin cx += dx; cy -= dy; cz += circ_angle(n); end
        end
        if (flip) begin cx = -cx; cy = -cy; end
        px = scale_clamp(e * cx, k, sat);
        py = scale_clamp(e * cy, k, sat);
        pt.px = px[31:0];
        pt.py = py[31:0];
        pt.ovf = sat;
        pending.push_back(pt);
    endfunction

    function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endfunction

    // Check one accepted point against the oldest expectation
    function void check_point(logic [63:0] data, logic ovf);
        point_t pt;
        if (pending.size() == 0)
        begin
            report_mismatch("unexpected point", data[31:0], '0);
            return;
        end
        pt = pending.pop_front();
        if (data[31:0] !== pt.px) report_mismatch("coord_x", data[31:0], pt.px);
        if (data[63:32] !== pt.py) report_mismatch("coord_y", data[63:32], pt.py);
        if (ovf !== pt.ovf) report_mismatch("overflow", {31'b0, ovf}, {31'b0, pt.ovf});
    endfunction
endclass

module log_spiral_point_generator_test;
    import lsp_pkg::*;

    localparam int DRAIN_CYCLES = CORDIC_STAGES_DEF + FRONT_STAGES + BACK_STAGES + 8;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    spiral_scoreboard board;
    int src_idle_pct;
    int sink_idle_pct;

    log_spiral_point_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Check accepted results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_point(m_tdata, m_tuser[0]);
    end

    // Stall the receiver at random
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Send one position item, with a random gap before it
    task automatic send_position(logic [15:0] pos);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_position(pos);
        @(negedge clk);
    endtask

    // Hold until all points are back, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_growth(logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.growth = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random position, biased toward fold boundaries and extremes
    function automatic logic [15:0] pick_position();
        logic [15:0] edges[8] = '{16'h0000, 16'h2000, 16'h2001, 16'h4000,
                                  16'h7FFF, 16'h8000, 16'hE000, 16'hDFFF};
        if ($urandom_range(9) == 0)
            return edges[$urandom_range(7)] + 16'($urandom_range(2)) - 16'd1;
        return 16'($urandom());
    endfunction

    initial
    begin
        #(8 * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [15:0] rates[8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h1000,
                                  16'hF000, 16'h0400, 16'hFE00, 16'h4000};
        logic [15:0] directed[14] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001,
                                      16'h4000, 16'hC000, 16'h2000, 16'h2001,
                                      16'hE000, 16'hDFFF, 16'h0001, 16'hFFFF,
                                      16'h3FFF, 16'hA000};
        int phase;
        int r;
        int j;
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        src_idle_pct = 30;
        sink_idle_pct = 45;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed items under the reset growth, then at both extremes
        foreach (directed[j]) send_position(directed[j]);
        write_growth(16'h7FFF);
        foreach (directed[j]) send_position(directed[j]);
        write_growth(16'h8000);
        for (j = 0; j < 6; j++) send_position(directed[j]);

        // Random items over three idling phases and several growth settings
        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 30 : (phase == 1) ? 45 : 0;
            sink_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 30 : 0;
            for (r = 0; r < 8; r++)
            begin
                write_growth((r == 7) ? 16'($urandom()) : rates[r]);
                for (j = 0; j < 54; j++)
                    send_position(pick_position());
            end
        end

        wait_drained();
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
